[src/arctan_series_degrees_macros.svh]
// ----------------------------------------------------------------------------
// arctan_series_degrees assertion macros
// property helpers shared by the datapath modules; clocked on clk, off in rst
// ----------------------------------------------------------------------------
`ifndef ARCTAN_SERIES_DEGREES_MACROS_SVH
`define ARCTAN_SERIES_DEGREES_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ACSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acsd check failed");
`define ACSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acsd check failed");
`else
`define ACSD_ASSERT_IMP(label, ante, cons)
`define ACSD_ASSERT_NXT(label, ante, cons)
`endif

`endif

[src/acsd_pkg.sv]
// ----------------------------------------------------------------------------
// acsd_pkg
// shared types and constants of the arctangent datapath
// ----------------------------------------------------------------------------
package acsd_pkg;

  localparam int ACSD_TERM_PAIRS = 5;

  localparam logic [30:0] ACSD_HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] ACSD_ONE_Q16     = 32'd65536;
  localparam logic [31:0] ACSD_REM_START   = 32'd32768;

  typedef struct packed {
    logic valid;
    logic neg;
    logic big;
  } acsd_tag_t;

  typedef struct packed {
    acsd_tag_t   tag;
    logic [31:0] mag;
    logic [30:0] half;
    logic [31:0] rem;
    logic [30:0] quot;
  } acsd_div_t;

  typedef struct packed {
    acsd_tag_t          tag;
    logic [30:0]        y2;
    logic [30:0]        pw;
    logic signed [32:0] sum;
  } acsd_ser_t;

endpackage

[src/acsd_div_cell.sv]
// ----------------------------------------------------------------------------
// acsd_div_cell
// one restoring step of the reciprocal divider, one quotient bit per cell
// ----------------------------------------------------------------------------
module acsd_div_cell #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  acsd_pkg::acsd_div_t din,
  output acsd_pkg::acsd_div_t dout
);
  import acsd_pkg::*;
  `include "arctan_series_degrees_macros.svh"

  logic [32:0] trial;
  logic [32:0] diff;
  acsd_div_t   dout_next;

  always_comb begin
    trial     = {din.rem, din.half[BIT]};
    diff      = trial - {1'b0, din.mag};
    dout_next = din;
    if (trial >= {1'b0, din.mag}) begin
      dout_next.rem       = diff[31:0];
      dout_next.quot[BIT] = 1'b1;
    end else begin
      dout_next.rem = trial[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.tag.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

  // partial remainder stays below the divisor on the reciprocal path
  `ACSD_ASSERT_IMP(a_rem_below_div, dout.tag.valid && dout.tag.big, dout.rem < dout.mag)

endmodule

[src/acsd_series_cell.sv]
// ----------------------------------------------------------------------------
// acsd_series_cell
// one taylor term: next odd power and rounded term divided by 2n+1
// ----------------------------------------------------------------------------
module acsd_series_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  acsd_pkg::acsd_ser_t din,
  output acsd_pkg::acsd_ser_t dout
);
  import acsd_pkg::*;

  // exact division by the odd constant via reciprocal multiply
  localparam int          DEN      = 2 * IDX + 1;
  localparam int          SH       = 31 + $clog2(DEN);
  localparam logic [63:0] MUL_W    = ((64'd1 << SH) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [31:0] MUL      = MUL_W[31:0];
  localparam logic [30:0] HALF_DEN = 31'(DEN / 2);
  localparam bit          SUBTRACT = (IDX % 2) != 0;

  acsd_tag_t          a_tag;
  logic [30:0]        a_y2;
  logic signed [32:0] a_sum;
  logic [61:0]        a_pp;
  logic [62:0]        a_tp;

  logic [61:0]        pw_prod;
  logic [62:0]        term_prod;
  logic [61:0]        pw_rnd;
  logic [62:0]        term_sh;
  logic signed [32:0] term_s;
  acsd_ser_t          dout_next;

  assign pw_prod   = {31'b0, din.pw} * {31'b0, din.y2};
  assign term_prod = {32'b0, din.pw + HALF_DEN} * {31'b0, MUL};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag.valid <= 1'b0;
    end else if (en) begin
      a_tag <= din.tag;
      a_y2  <= din.y2;
      a_sum <= din.sum;
      a_pp  <= pw_prod;
      a_tp  <= term_prod;
    end
  end

  always_comb begin
    pw_rnd        = a_pp + (62'd1 << 29);
    term_sh       = a_tp >> SH;
    term_s        = signed'({2'b00, term_sh[30:0]});
    dout_next.tag = a_tag;
    dout_next.y2  = a_y2;
    dout_next.pw  = pw_rnd[60:30];
    dout_next.sum = SUBTRACT ? (a_sum - term_s) : (a_sum + term_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.tag.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

[src/acsd_deg_conv.sv]
// ----------------------------------------------------------------------------
// acsd_deg_conv
// radians q30 to degrees q24: round(rad * 3581 / 4000), sign restored
// ----------------------------------------------------------------------------
module acsd_deg_conv (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  acsd_pkg::acsd_tag_t tag,
  input  logic [30:0]         rad,
  output logic                valid,
  output logic [31:0]         angle
);
  import acsd_pkg::*;
  `include "arctan_series_degrees_macros.svh"

  // wh / 125 and (rh:wl) / 125 by reciprocal multiply
  localparam logic [19:0] MH = 20'd536871;
  localparam logic [26:0] ML = 27'd68719477;
  localparam logic [18:0] D125 = 19'd125;

  acsd_tag_t   t1, t2, t3, t4;
  logic [37:0] w1;
  logic [12:0] qh2, qh3, qh4;
  logic [18:0] wh2, wl2;
  logic [25:0] tl3;
  logic [18:0] ql4;

  logic [42:0] scaled;
  logic [38:0] qh_prod;
  logic [18:0] rh_full;
  logic [52:0] ql_prod;
  logic [31:0] deg;

  assign scaled  = {12'b0, rad} * 43'd3581 + 43'd2000;
  assign qh_prod = {20'b0, w1[37:19]} * {19'b0, MH};
  assign rh_full = wh2 - {6'b0, qh2} * D125;
  assign ql_prod = {27'b0, tl3} * {26'b0, ML};
  assign deg     = {qh4, ql4};

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
      t2.valid <= 1'b0;
      t3.valid <= 1'b0;
      t4.valid <= 1'b0;
      valid    <= 1'b0;
    end else if (en) begin
      t1    <= tag;
      w1    <= scaled[42:5];
      t2    <= t1;
      qh2   <= qh_prod[38:26];
      wh2   <= w1[37:19];
      wl2   <= w1[18:0];
      t3    <= t2;
      qh3   <= qh2;
      tl3   <= {rh_full[6:0], wl2};
      t4    <= t3;
      qh4   <= qh3;
      ql4   <= ql_prod[51:33];
      valid <= t4.valid;
      angle <= t4.neg ? (~deg + 32'd1) : deg;
    end
  end

  // high quotient digit never overshoots, high remainder stays below 125
  `ACSD_ASSERT_IMP(a_qh_exact, t2.valid, {6'b0, qh2} * D125 <= wh2)
  `ACSD_ASSERT_IMP(a_rh_range, t3.valid, tl3[25:19] < 7'd125)

endmodule

[src/arctan_series_degrees.sv]
// ----------------------------------------------------------------------------
// arctan_series_degrees
// pipelined arctangent of a q16.16 argument, answered in q8.24 degrees
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one word per argument, in order.
// The pipeline is a row of cells: 31 divider cells form 1/|x| for arguments
// above one, a squaring stage, then one two-stage cell per taylor term, then
// a five stage degree converter. The whole row stalls only while a finished
// word waits at the output and angle_ready is low.
// ----------------------------------------------------------------------------
module arctan_series_degrees #(
  parameter int TERM_PAIRS = acsd_pkg::ACSD_TERM_PAIRS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               arg_valid,
  output logic               arg_ready,
  input  logic signed [31:0] argument,
  output logic               angle_valid,
  input  logic               angle_ready,
  output logic signed [31:0] angle_degrees
);
  import acsd_pkg::*;

  localparam int TERMS = 2 * TERM_PAIRS;

  // global advance: every stage moves unless the output word is held
  logic en;
  assign en        = !angle_valid || angle_ready;
  assign arg_ready = en;

  // magnitude and branch select; -32768.0 wraps to 2^31 naturally
  logic [31:0] raw;
  logic [31:0] mag;
  acsd_div_t   div_w [0:31];

  assign raw = argument;
  assign mag = raw[31] ? (~raw + 32'd1) : raw;

  // tag, magnitude, numerator 2^46 + mag/2 with its top part preloaded, quotient
  assign div_w[0] = {arg_valid && arg_ready, raw[31], mag > ACSD_ONE_Q16,
                     mag, mag[31:1], ACSD_REM_START, 31'b0};

  // reciprocal divider row, msb first
  for (genvar k = 0; k < 31; k++) begin : g_div
    acsd_div_cell #(.BIT(30 - k)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (div_w[k]),
      .dout (div_w[k + 1])
    );
  end

  // series argument: reciprocal or |x| scaled to q30, then its square
  logic [30:0] y;
  acsd_tag_t   sq_tag;
  logic [30:0] sq_y;
  logic [61:0] sq_prod;
  logic [61:0] sq_rnd;

  assign y = div_w[31].tag.big ? div_w[31].quot : {div_w[31].mag[16:0], 14'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_tag.valid <= 1'b0;
    end else if (en) begin
      sq_tag  <= div_w[31].tag;
      sq_y    <= y;
      sq_prod <= {31'b0, y} * {31'b0, y};
    end
  end

  assign sq_rnd = sq_prod + (62'd1 << 29);

  // taylor row, one term per cell
  acsd_ser_t ser_w [0:TERMS];

  // tag, y^2, first odd power, empty sum
  assign ser_w[0] = {sq_tag, sq_rnd[60:30], sq_y, 33'd0};

  for (genvar n = 0; n < TERMS; n++) begin : g_ser
    acsd_series_cell #(.IDX(n)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (ser_w[n]),
      .dout (ser_w[n + 1])
    );
  end

  // angle in radians: pi/2 minus the series above one, clamped at zero
  logic signed [32:0] rad_full;
  logic [30:0]        rad;

  assign rad_full = ser_w[TERMS].tag.big
                  ? (signed'({2'b00, ACSD_HALF_PI_Q30}) - ser_w[TERMS].sum)
                  : ser_w[TERMS].sum;
  assign rad      = rad_full[32] ? '0 : rad_full[30:0];

  logic [31:0] angle;

  acsd_deg_conv u_deg (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .tag   (ser_w[TERMS].tag),
    .rad   (rad),
    .valid (angle_valid),
    .angle (angle)
  );

  assign angle_degrees = signed'(angle);

endmodule
